/* hdl/swtn_pkg.sv */
// ============================================================================
// swtn_pkg - shared types and constants for the skin weight top-4 normalizer
// Payload structs for the pair and result channels, slot cell control codes,
// and the Q1.15 constants used by the normalizer.
// ============================================================================
package swtn_pkg;

    // Default configuration
    localparam int INFLUENCES_DEF = 4;
    localparam int JOINT_BITS_DEF = 8;

    // Fixed field widths
    localparam int JOINT_W  = 8;
    localparam int WEIGHT_W = 16;
    localparam int SLOT_W   = 2;

    // Q1.15 unity and divider length (one quotient bit per step)
    localparam int unsigned Q15_ONE = 32768;
    localparam int DIV_STEPS = 16;

    // One influence pair request
    typedef struct packed {
        logic [JOINT_W-1:0]  joint_index;
        logic [WEIGHT_W-1:0] weight;
        logic                has_pair;
        logic                last_pair;
    } pair_t;

    // One normalized influence
    typedef struct packed {
        logic [JOINT_W-1:0]  out_joint;
        logic [WEIGHT_W-1:0] out_weight;
        logic [SLOT_W-1:0]   slot_number;
        logic                last_influence;
    } result_t;

    // What every slot cell does this cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_SORT,
        CELL_ROTATE,
        CELL_CLEAR
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t mode;
        logic       sort_odd;
    } cell_ctrl_t;

endpackage

/* hdl/skin_weight_top4_normalize.sv */
// ============================================================================
// skin_weight_top4_normalize - keep top influences of a vertex and normalize
// Collects (joint, weight) pairs in a chain of slot cells, keeps the largest
// weights once a vertex overflows, and emits the slots scaled to sum 1.0.
// ============================================================================
//
//  channel  | dir | handshake                  | payload
//  ---------+-----+----------------------------+------------------------
//  pair     | in  | pair_valid / pair_ready     | swtn_pkg::pair_t
//  result   | out | result_valid / result_ready | swtn_pkg::result_t
//
//  A pair that appends or inserts is taken in S_IDLE. The pair that first
//  overflows the slots passes through S_SORT, one odd/even sort phase per
//  slot in the cell chain, then S_INSERT. A closing request sums the slots
//  by rotating the chain in S_SUM, then per result runs S_DIV_START, the
//  divider in S_DIV_WAIT (skipped when the sum is 0 or 1.0) and S_PUT.
//  Reset clears the slots and the pair count. A stalled result only holds the
//  emit sequence; the output register lets the block take the next pair.
//
module skin_weight_top4_normalize #(
    parameter int INFLUENCES = swtn_pkg::INFLUENCES_DEF,
    parameter int JOINT_BITS = swtn_pkg::JOINT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pair_valid,
    output logic              pair_ready,
    input  swtn_pkg::pair_t   pair,
    output logic              result_valid,
    input  logic              result_ready,
    output swtn_pkg::result_t result
);
    import swtn_pkg::*;

    localparam int CNT_W  = $clog2(INFLUENCES + 2);
    localparam int IDX_W  = $clog2(INFLUENCES + 1);
    localparam int SUM_W  = WEIGHT_W + $clog2(INFLUENCES + 1);
    localparam int JEXT_W = JOINT_W + JOINT_BITS;
    localparam int SEXT_W = IDX_W + SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT,
        S_INSERT,
        S_SUM,
        S_DIV_START,
        S_DIV_WAIT,
        S_PUT
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [IDX_W-1:0]      phase_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [JOINT_BITS-1:0] pend_joint_reg;
    logic [WEIGHT_W-1:0]   pend_weight_reg;
    logic                  pend_last_reg;
    logic [WEIGHT_W-1:0]   quot_reg;
    logic                  result_valid_reg;
    result_t               result_reg;

    logic                  accept;
    logic                  out_free;
    logic                  last_idx;
    logic                  bypass;
    logic                  div_start;
    logic                  div_done;
    logic [WEIGHT_W-1:0]   div_quot;
    logic [JEXT_W-1:0]     in_joint_ext;
    logic [JEXT_W-1:0]     out_joint_ext;
    logic [SEXT_W-1:0]     slot_ext;
    logic [JOINT_BITS-1:0] in_joint;
    logic [JOINT_BITS-1:0] new_joint;
    logic [WEIGHT_W-1:0]   new_weight;
    cell_ctrl_t            ctrl;

    logic [JOINT_BITS-1:0] cell_joint  [INFLUENCES];
    logic [WEIGHT_W-1:0]   cell_weight [INFLUENCES];
    logic                  cell_gt     [INFLUENCES];

    // handshake and small decodes
    assign pair_ready    = (state_reg == S_IDLE);
    assign accept        = pair_valid && pair_ready;
    assign out_free      = !result_valid_reg || result_ready;
    assign last_idx      = (idx_reg == IDX_W'(INFLUENCES - 1));
    assign bypass        = (sum_reg == '0) || (sum_reg == SUM_W'(Q15_ONE));
    assign div_start     = (state_reg == S_DIV_START) && !bypass;
    assign in_joint_ext  = JEXT_W'(pair.joint_index);
    assign in_joint      = in_joint_ext[JOINT_BITS-1:0];
    assign out_joint_ext = JEXT_W'(cell_joint[0]);
    assign slot_ext      = SEXT_W'(idx_reg);
    assign new_joint     = (state_reg == S_IDLE) ? in_joint : pend_joint_reg;
    assign new_weight    = (state_reg == S_IDLE) ? pair.weight : pend_weight_reg;

    // chain control
    always_comb
    begin
        ctrl.mode     = CELL_HOLD;
        ctrl.sort_odd = phase_reg[0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept && pair.has_pair)
                begin
                    if (count_reg < CNT_W'(INFLUENCES))
                        ctrl.mode = CELL_APPEND;
                    else if (count_reg > CNT_W'(INFLUENCES))
                        ctrl.mode = CELL_INSERT;
                end
            end
            S_SORT:   ctrl.mode = CELL_SORT;
            S_INSERT: ctrl.mode = CELL_INSERT;
            S_SUM:    ctrl.mode = CELL_ROTATE;
            S_PUT:
            begin
                if (out_free)
                    ctrl.mode = last_idx ? CELL_CLEAR : CELL_ROTATE;
            end
            default:  ctrl.mode = CELL_HOLD;
        endcase
    end

    // slot cell chain; the last cell wraps to slot 0 for rotation
    for (genvar k = 0; k < INFLUENCES; k++)
    begin : g_cell
        logic [JOINT_BITS-1:0] pj, nj;
        logic [WEIGHT_W-1:0]   pw, nw;
        logic                  pg;

        if (k == 0)
        begin : g_first
            assign pj = '0;
            assign pw = '0;
            assign pg = 1'b0;
        end
        else
        begin : g_link
            assign pj = cell_joint[k-1];
            assign pw = cell_weight[k-1];
            assign pg = cell_gt[k-1];
        end

        if (k == INFLUENCES - 1)
        begin : g_wrap
            assign nj = cell_joint[0];
            assign nw = cell_weight[0];
        end
        else
        begin : g_next
            assign nj = cell_joint[k+1];
            assign nw = cell_weight[k+1];
        end

        swtn_cell #(
            .INFLUENCES (INFLUENCES),
            .JOINT_BITS (JOINT_BITS),
            .IDX        (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .append_sel  (count_reg == CNT_W'(k)),
            .new_joint   (new_joint),
            .new_weight  (new_weight),
            .prev_joint  (pj),
            .prev_weight (pw),
            .prev_gt     (pg),
            .next_joint  (nj),
            .next_weight (nw),
            .joint       (cell_joint[k]),
            .weight      (cell_weight[k]),
            .gt          (cell_gt[k])
        );
    end

    // weight scaler
    swtn_div #(
        .SUM_W (SUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cell_weight[0]),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            phase_reg        <= '0;
            idx_reg          <= '0;
            sum_reg          <= '0;
            pend_joint_reg   <= '0;
            pend_weight_reg  <= '0;
            pend_last_reg    <= 1'b0;
            quot_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            // in S_PUT the output register is reloaded whenever it frees up
            if (result_valid_reg && result_ready && (state_reg != S_PUT))
                result_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (pair.has_pair && (count_reg == CNT_W'(INFLUENCES)))
                        begin
                            // first overflow: sort slots, then insert
                            pend_joint_reg  <= in_joint;
                            pend_weight_reg <= pair.weight;
                            pend_last_reg   <= pair.last_pair;
                            count_reg       <= CNT_W'(INFLUENCES + 1);
                            phase_reg       <= '0;
                            state_reg       <= S_SORT;
                        end
                        else
                        begin
                            if (pair.has_pair && (count_reg < CNT_W'(INFLUENCES)))
                                count_reg <= count_reg + 1'b1;
                            if (pair.last_pair)
                            begin
                                sum_reg   <= '0;
                                idx_reg   <= '0;
                                state_reg <= S_SUM;
                            end
                        end
                    end
                end
                S_SORT:
                begin
                    phase_reg <= phase_reg + 1'b1;
                    if (phase_reg == IDX_W'(INFLUENCES - 1))
                        state_reg <= S_INSERT;
                end
                S_INSERT:
                begin
                    if (pend_last_reg)
                    begin
                        sum_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= S_SUM;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_SUM:
                begin
                    // slot 0 passes by once per cycle
                    sum_reg <= sum_reg + SUM_W'(cell_weight[0]);
                    if (last_idx)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_DIV_START;
                    end
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DIV_START:
                begin
                    if (bypass)
                    begin
                        quot_reg  <= cell_weight[0];
                        state_reg <= S_PUT;
                    end
                    else
                        state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        quot_reg  <= div_quot;
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    if (out_free)
                    begin
                        result_reg.out_joint      <= out_joint_ext[JOINT_W-1:0];
                        result_reg.out_weight     <= quot_reg;
                        result_reg.slot_number    <= slot_ext[SLOT_W-1:0];
                        result_reg.last_influence <= last_idx;
                        result_valid_reg          <= 1'b1;
                        if (last_idx)
                        begin
                            count_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_DIV_START;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* hdl/swtn_cell.sv */
// ============================================================================
// swtn_cell - one slot of the influence chain
// Holds a (joint, weight) pair. Appends, takes part in a stable descending
// insert, in odd/even transposition sort phases, rotates toward slot 0 and clears.
// ============================================================================
module swtn_cell #(
    parameter int INFLUENCES = swtn_pkg::INFLUENCES_DEF,
    parameter int JOINT_BITS = swtn_pkg::JOINT_BITS_DEF,
    parameter int IDX        = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  swtn_pkg::cell_ctrl_t          ctrl,
    input  logic                          append_sel,
    input  logic [JOINT_BITS-1:0]         new_joint,
    input  logic [swtn_pkg::WEIGHT_W-1:0] new_weight,
    input  logic [JOINT_BITS-1:0]         prev_joint,
    input  logic [swtn_pkg::WEIGHT_W-1:0] prev_weight,
    input  logic                          prev_gt,
    input  logic [JOINT_BITS-1:0]         next_joint,
    input  logic [swtn_pkg::WEIGHT_W-1:0] next_weight,
    output logic [JOINT_BITS-1:0]         joint,
    output logic [swtn_pkg::WEIGHT_W-1:0] weight,
    output logic                          gt
);
    import swtn_pkg::*;

    localparam logic HAS_PREV = (IDX > 0);
    localparam logic HAS_NEXT = (IDX < INFLUENCES - 1);
    localparam logic IDX_ODD  = 1'(IDX % 2);
    localparam logic PREV_ODD = 1'((IDX + 1) % 2);

    logic [JOINT_BITS-1:0] joint_reg, joint_next;
    logic [WEIGHT_W-1:0]   weight_reg, weight_next;
    logic                  lower_act, upper_act;

    // new pair beats this slot
    assign gt = new_weight > weight_reg;

    // next slot contents
    always_comb
    begin
        joint_next  = joint_reg;
        weight_next = weight_reg;
        // this cell is the lower / upper half of a compare pair this phase
        lower_act = HAS_NEXT && (ctrl.sort_odd == IDX_ODD);
        upper_act = HAS_PREV && (ctrl.sort_odd == PREV_ODD);
        case (ctrl.mode)
            CELL_APPEND:
            begin
                if (append_sel)
                begin
                    joint_next  = new_joint;
                    weight_next = new_weight;
                end
            end
            CELL_INSERT:
            begin
                // slots are sorted: first slot the new weight beats takes it,
                // every slot after it shifts down one
                if (HAS_PREV && prev_gt)
                begin
                    joint_next  = prev_joint;
                    weight_next = prev_weight;
                end
                else if (gt)
                begin
                    joint_next  = new_joint;
                    weight_next = new_weight;
                end
            end
            CELL_SORT:
            begin
                // strict compare keeps equal weights in order
                if (lower_act && (next_weight > weight_reg))
                begin
                    joint_next  = next_joint;
                    weight_next = next_weight;
                end
                else if (upper_act && (weight_reg > prev_weight))
                begin
                    joint_next  = prev_joint;
                    weight_next = prev_weight;
                end
            end
            CELL_ROTATE:
            begin
                joint_next  = next_joint;
                weight_next = next_weight;
            end
            CELL_CLEAR:
            begin
                joint_next  = '0;
                weight_next = '0;
            end
            default:
            begin
                joint_next  = joint_reg;
                weight_next = weight_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            joint_reg  <= '0;
            weight_reg <= '0;
        end
        else
        begin
            joint_reg  <= joint_next;
            weight_reg <= weight_next;
        end
    end

    assign joint  = joint_reg;
    assign weight = weight_reg;

endmodule

/* hdl/swtn_div.sv */
// ============================================================================
// swtn_div - serial Q1.15 weight scaler
// Computes floor(w * 32768 / sum) for w <= sum, one quotient bit per cycle
// by restoring division. The integer bit comes first, then 15 fraction bits.
// ============================================================================
module swtn_div #(
    parameter int SUM_W = 19
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [swtn_pkg::WEIGHT_W-1:0] dividend,
    input  logic [SUM_W-1:0]              divisor,
    output logic                          done,
    output logic [swtn_pkg::WEIGHT_W-1:0] quotient
);
    import swtn_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SUM_W:0]      rem_reg;
    logic [WEIGHT_W-1:0] quot_reg;
    logic [SUM_W:0]      cand;
    logic [SUM_W:0]      div_ext;
    logic                take;

    // trial subtract; first step uses the remainder unshifted
    always_comb
    begin
        cand    = (step_reg == '0) ? rem_reg : {rem_reg[SUM_W-1:0], 1'b0};
        div_ext = {1'b0, divisor};
        take    = cand >= div_ext;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            // done pulses for one cycle after the last step
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(DIV_STEPS - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= (SUM_W + 1)'(dividend);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= take ? (cand - div_ext) : cand;
            quot_reg <= {quot_reg[WEIGHT_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule
